@@ design/pqd_pkg.sv @@
package pqd_pkg;

  // Number of error-feedback taps and fraction bits of the working sum.
  localparam int TAPS     = 9;
  localparam int ACC_FRAC = 30;

  // Shaping coefficients in Q28, newest error first.
  localparam logic signed [31:0] TAP_Q28 [TAPS] = '{
    32'sd647466320, -32'sd904627487, 32'sd1056830390, -32'sd1120449593,
    32'sd900064084, -32'sd591900180, 32'sd343865819, -32'sd152739774,
    32'sd22736483
  };

  // Constants of the seed mixer.
  localparam logic [63:0] SM_GAMMA = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2  = 64'h94d049bb133111eb;

  // Register reset values.
  localparam logic [5:0]  RST_BIT_DEPTH = 6'd24;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_BIT_DEPTH   = 2'd0,
    CFG_DITHER_MODE = 2'd1,
    CFG_SEED        = 2'd2
  } pqd_cfg_idx_t;

  // Dither modes.
  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_TPDF   = 2'd1,
    MODE_SHAPED = 2'd2
  } pqd_mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SEED,
    ST_MAC,
    ST_DITHER,
    ST_ROUND,
    ST_WRITE
  } pqd_state_t;

endpackage

@@ design/pqd_in_if.sv @@
interface pqd_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        channel;
  logic signed [31:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

@@ design/pqd_out_if.sv @@
interface pqd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_channel;
  logic signed [31:0] code;
  logic signed [31:0] code_left_justified;
  logic               clipped;

  modport source (output valid, output out_channel, output code,
                  output code_left_justified, output clipped, input ready);
  modport sink   (input valid, input out_channel, input code,
                  input code_left_justified, input clipped, output ready);
endinterface

@@ design/pqd_cfg_if.sv @@
interface pqd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/pqd_ram.sv @@
module pqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/pqd_seed.sv @@
module pqd_seed (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] value,
  output logic        done,
  output logic [31:0] result
);
  import pqd_pkg::*;

  logic        busy_r;
  logic        round_r;
  logic [2:0]  cnt_r;
  logic [63:0] x_r;
  logic [63:0] acc_r;
  logic [63:0] prod_r;
  logic        done_r;
  logic [31:0] result_r;

  logic [63:0] cst;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul;
  logic [63:0] acc_sum;
  logic [63:0] w0;
  logic [63:0] fin;

  // Operand selection for the three partial products of a 64-bit low product.
  always_comb begin
    cst = round_r ? SM_MUL2 : SM_MUL1;
    case (cnt_r)
      3'd1: begin
        op_a = x_r[31:0];
        op_b = cst[63:32];
      end
      3'd2: begin
        op_a = x_r[63:32];
        op_b = cst[31:0];
      end
      default: begin
        op_a = x_r[31:0];
        op_b = cst[31:0];
      end
    endcase
    mul     = 64'(op_a) * 64'(op_b);
    acc_sum = acc_r + {prod_r[31:0], 32'd0};
    w0      = 64'(value) + SM_GAMMA;
    fin     = acc_r ^ (acc_r >> 31);
  end

  // Control of the two multiply rounds.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= 1'b0;
      cnt_r   <= 3'd0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        round_r <= 1'b0;
        cnt_r   <= 3'd0;
      end else if (busy_r) begin
        if (cnt_r == 3'd4) begin
          cnt_r <= 3'd0;
          if (round_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end else begin
            round_r <= 1'b1;
          end
        end else begin
          cnt_r <= cnt_r + 3'd1;
        end
      end
    end
  end

  // Datapath of the mixer.
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= w0 ^ (w0 >> 30);
    end else if (busy_r) begin
      case (cnt_r)
        3'd0: begin
          prod_r <= mul;
        end
        3'd1: begin
          acc_r  <= prod_r;
          prod_r <= mul;
        end
        3'd2: begin
          acc_r  <= acc_sum;
          prod_r <= mul;
        end
        3'd3: begin
          acc_r <= acc_sum;
        end
        default: begin
          if (!round_r) begin
            x_r <= acc_r ^ (acc_r >> 27);
          end else begin
            result_r <= (fin[31:0] == 32'd0) ? 32'd1 : fin[31:0];
          end
        end
      endcase
    end
  end

  assign done   = done_r;
  assign result = result_r;

endmodule

@@ design/pqd_tap_mac.sv @@
module pqd_tap_mac #(
  parameter int ERROR_FRACTION_BITS = 24,
  parameter int COEFF_FRACTION_BITS = 20
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            start,
  input  logic [pqd_pkg::TAPS*(ERROR_FRACTION_BITS+3)-1:0] hist,
  output logic                                            done,
  output logic signed [63:0]                              sum
);
  import pqd_pkg::*;

  localparam int EW  = ERROR_FRACTION_BITS + 3;
  localparam int CW  = COEFF_FRACTION_BITS + 4;
  localparam int PW  = EW + CW;
  localparam int TW  = PW + 3;
  localparam int CSR = (COEFF_FRACTION_BITS < 28) ? 28 - COEFF_FRACTION_BITS : 0;
  localparam int CSL = (COEFF_FRACTION_BITS > 28) ? COEFF_FRACTION_BITS - 28 : 0;
  localparam logic signed [63:0] CRND = (CSR > 0) ? (64'sd1 <<< (CSR - 1)) : 64'sd0;
  localparam int PFR = ERROR_FRACTION_BITS + COEFF_FRACTION_BITS;
  localparam int PSR = (PFR > ACC_FRAC) ? PFR - ACC_FRAC : 0;
  localparam int PSL = (PFR < ACC_FRAC) ? ACC_FRAC - PFR : 0;
  localparam logic signed [TW-1:0] PRND = (PSR > 0) ? (TW'(1) <<< (PSR - 1)) : '0;

  logic                 busy_r;
  logic                 pv_r;
  logic                 done_r;
  logic [3:0]           k_r;
  logic signed [PW-1:0] prod_r;
  logic signed [63:0]   sum_r;

  logic signed [EW-1:0] h;
  logic signed [CW-1:0] cf;
  logic signed [TW-1:0] term;

  // Coefficient rounded from Q28 to the coefficient format, ties upward.
  function automatic logic signed [CW-1:0] coeff(input logic [3:0] k);
    logic signed [63:0] q;
    q = 64'(TAP_Q28[k]);
    q = ((q + CRND) >>> CSR) <<< CSL;
    return q[CW-1:0];
  endfunction

  // One tap product per cycle into the product register; the registered product is rounded to Q30 and summed.
  always_comb begin
    h    = hist[k_r*EW +: EW];
    cf   = coeff(k_r);
    term = ((TW'(prod_r) + PRND) >>> PSR) <<< PSL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      k_r    <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        pv_r   <= 1'b0;
        k_r    <= 4'd0;
      end else if (busy_r) begin
        pv_r <= (k_r < 4'(TAPS));
        if (k_r < 4'(TAPS)) begin
          k_r <= k_r + 4'd1;
        end else if (pv_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_r <= '0;
    end else if (busy_r) begin
      if (k_r < 4'(TAPS)) begin
        prod_r <= cf * h;
      end
      if (pv_r) begin
        sum_r <= sum_r + 64'(term);
      end
    end
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

@@ design/pcm_requantiser_noise_shaped_dither_core.sv @@
// Requantiser for Q1.31 audio samples with triangular dither and nine-tap
// error-feedback noise shaping.
// in_ch carries one sample and its channel number per transaction; out_ch
// returns one result per input: the channel, the clipped code, the code
// left-justified to 32 bits and a clip flag. cfg_ch writes bit_depth (0),
// dither_mode (1) and seed (2); any of these writes marks every channel
// for reseeding. The user must write configuration while the block is
// idle; the block does not enforce this. Per-channel generator and error
// history sit in two RAMs with one read and one write port, read, updated
// and written back once per sample. A sample passes through the read,
// dither, round and write-back states before its result is loaded, and
// the next sample is taken on the return to idle; in shaped mode the
// nine-step tap multiply-accumulate runs between read and dither. The first
// item of a channel after reset or a configuration write runs the 64-bit
// seed mixer on one 32x32 multiplier instead; it runs as long as the tap sum.
// The result register frees the core for the next sample while a result
// waits; when the receiver stalls, the next result is held in the write-back
// step until the register empties, and input is refused meanwhile.
// Reset restores the register defaults and marks all channels for seeding;
// no clearing pass is needed, since seeding zeroes a channel's history.
module pcm_requantiser_noise_shaped_dither_core #(
  parameter int CHANNELS            = 8,
  parameter int ERROR_FRACTION_BITS = 24,
  parameter int COEFF_FRACTION_BITS = 20
) (
  input  logic    clk,
  input  logic    rst_n,
  pqd_in_if.sink  in_ch,
  pqd_out_if.source out_ch,
  pqd_cfg_if.sink cfg_ch
);
  import pqd_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EW   = ERROR_FRACTION_BITS + 3;
  localparam int HW   = TAPS * EW;
  localparam int ESR  = (ERROR_FRACTION_BITS < ACC_FRAC) ? ACC_FRAC - ERROR_FRACTION_BITS : 0;
  localparam int ESL  = (ERROR_FRACTION_BITS > ACC_FRAC) ? ERROR_FRACTION_BITS - ACC_FRAC : 0;
  localparam logic signed [63:0] ERND = (ESR > 0) ? (64'sd1 <<< (ESR - 1)) : 64'sd0;

  pqd_state_t state_r, state_nxt;

  // Configuration and seeding flags.
  logic [5:0]          bd_r;
  logic [1:0]          mode_r;
  logic [31:0]         seed_r;
  logic [CHANNELS-1:0] need_r;

  // Per-item working registers.
  logic [2:0]          ch_in_r;
  logic [CH_W-1:0]     ch_r;
  logic signed [63:0]  acc_r;
  logic signed [63:0]  wanted_r;
  logic [31:0]         gen_r;
  logic [HW-1:0]       hist_r;
  logic signed [33:0]  rounded_r;

  // Result register.
  logic               out_valid_r;
  logic [2:0]         out_ch_r;
  logic signed [31:0] code_r;
  logic signed [31:0] lj_r;
  logic               clip_r;

  // Sequencer outputs.
  logic in_acc;
  logic mem_re;
  logic mem_we;
  logic seed_start;
  logic mac_start;
  logic out_load;

  logic [31:0] gen_rdata;
  logic [HW-1:0] hist_rdata;
  logic        seed_done;
  logic [31:0] seed_res;
  logic        mac_done;
  logic signed [63:0] mac_sum;

  logic [2:0]         ch_m;
  logic [CH_W-1:0]    ch_mod;
  logic [5:0]         bits;
  logic               shaped;
  logic               dithered;
  logic               seeding;
  logic [31:0]        x1;
  logic [31:0]        x2;
  logic signed [25:0] d_sum;
  logic [29:0]        frac;
  logic signed [33:0] flo;
  logic signed [33:0] rounded;
  logic signed [33:0] maxc;
  logic signed [33:0] code_c;
  logic               clip_c;
  logic [31:0]        lj_c;
  logic signed [63:0] err_full;
  logic signed [63:0] err_w;
  logic [HW-1:0]      hist_nxt;
  logic               cfg_acc;

  function automatic logic [31:0] xorshift(input logic [31:0] v);
    logic [31:0] t;
    t = v ^ (v << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // Channel number folded onto the available state.
  always_comb begin
    ch_m = in_ch.channel;
    for (int i = 0; i < 7; i++) begin
      if (32'(ch_m) >= CHANNELS) begin
        ch_m = ch_m - 3'(CHANNELS);
      end
    end
    ch_mod = CH_W'(ch_m);
  end

  // Effective word length and mode decode.
  always_comb begin
    if (bd_r < 6'd2) begin
      bits = 6'd2;
    end else if (bd_r > 6'd32) begin
      bits = 6'd32;
    end else begin
      bits = bd_r;
    end
    shaped   = (mode_r == MODE_SHAPED);
    dithered = (mode_r != MODE_PLAIN);
    seeding  = need_r[ch_r];
    cfg_acc  = cfg_ch.valid && cfg_ch.ready;
  end

  // Dither, rounding, clipping and error feedback.
  always_comb begin
    x1    = xorshift(gen_r);
    x2    = xorshift(x1);
    d_sum = $signed({2'b00, x1[31:8]}) + $signed({2'b00, x2[31:8]}) - 26'sd16777216;

    flo     = acc_r[63:30];
    frac    = acc_r[29:0];
    rounded = flo;
    if ((frac > 30'h2000_0000) || ((frac == 30'h2000_0000) && flo[0])) begin
      rounded = flo + 34'sd1;
    end

    maxc   = (34'sd1 <<< (bits - 6'd1)) - 34'sd1;
    code_c = rounded_r;
    clip_c = 1'b0;
    if (rounded_r > maxc) begin
      code_c = maxc;
      clip_c = 1'b1;
    end else if (rounded_r < -maxc) begin
      code_c = -maxc;
      clip_c = 1'b1;
    end
    lj_c = code_c[31:0] << (6'd32 - bits);

    err_full = wanted_r - (64'(rounded_r) <<< ACC_FRAC);
    err_w    = ((err_full + ERND) >>> ESR) <<< ESL;
    hist_nxt = shaped ? {hist_r[HW-EW-1:0], err_w[EW-1:0]} : hist_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (seeding) begin
          state_nxt = ST_SEED;
        end else if (shaped) begin
          state_nxt = ST_MAC;
        end else begin
          state_nxt = ST_DITHER;
        end
      end
      ST_SEED: begin
        if (seed_done) begin
          state_nxt = ST_DITHER;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          state_nxt = ST_DITHER;
        end
      end
      ST_DITHER: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ch.ready = 1'b0;
    mem_re      = 1'b0;
    mem_we      = 1'b0;
    seed_start  = 1'b0;
    mac_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        mem_re      = in_ch.valid;
      end
      ST_READ: begin
        seed_start = seeding;
        mac_start  = !seeding && shaped;
      end
      ST_WRITE: begin
        out_load = !out_valid_r || out_ch.ready;
        mem_we   = out_load;
      end
      default: begin
      end
    endcase
  end

  assign in_acc = in_ch.valid && in_ch.ready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bd_r        <= RST_BIT_DEPTH;
      mode_r      <= MODE_SHAPED;
      seed_r      <= '0;
      need_r      <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        unique case (cfg_ch.index)
          CFG_BIT_DEPTH: begin
            bd_r   <= cfg_ch.data[5:0];
            need_r <= '1;
          end
          CFG_DITHER_MODE: begin
            mode_r <= cfg_ch.data[1:0];
            need_r <= '1;
          end
          CFG_SEED: begin
            seed_r <= cfg_ch.data;
            need_r <= '1;
          end
          default: begin
          end
        endcase
      end else if (seed_start) begin
        need_r[ch_r] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers of the current sample.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_in_r <= in_ch.channel;
      ch_r    <= ch_mod;
      acc_r   <= 64'(in_ch.sample) <<< (bits - 6'd2);
    end
    unique case (state_r)
      ST_READ: begin
        gen_r  <= gen_rdata;
        hist_r <= hist_rdata;
      end
      ST_SEED: begin
        if (seed_done) begin
          gen_r  <= seed_res;
          hist_r <= '0;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          acc_r <= acc_r + mac_sum;
        end
      end
      ST_DITHER: begin
        wanted_r <= acc_r;
        if (dithered) begin
          gen_r <= x2;
          acc_r <= acc_r + (64'(d_sum) <<< 6);
        end
      end
      ST_ROUND: begin
        rounded_r <= rounded;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_ch_r <= ch_in_r;
      code_r   <= code_c[31:0];
      lj_r     <= lj_c;
      clip_r   <= clip_c;
    end
  end

  pqd_ram #(
    .WIDTH (32),
    .DEPTH (CHANNELS)
  ) u_gen_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ch_r),
    .wdata (gen_r),
    .re    (mem_re),
    .raddr (ch_mod),
    .rdata (gen_rdata)
  );

  pqd_ram #(
    .WIDTH (HW),
    .DEPTH (CHANNELS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (ch_r),
    .wdata (hist_nxt),
    .re    (mem_re),
    .raddr (ch_mod),
    .rdata (hist_rdata)
  );

  pqd_seed u_seed (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (seed_start),
    .value  (seed_r + 32'(ch_r)),
    .done   (seed_done),
    .result (seed_res)
  );

  pqd_tap_mac #(
    .ERROR_FRACTION_BITS (ERROR_FRACTION_BITS),
    .COEFF_FRACTION_BITS (COEFF_FRACTION_BITS)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mac_start),
    .hist  (hist_r),
    .done  (mac_done),
    .sum   (mac_sum)
  );

  assign out_ch.valid               = out_valid_r;
  assign out_ch.out_channel         = out_ch_r;
  assign out_ch.code                = code_r;
  assign out_ch.code_left_justified = lj_r;
  assign out_ch.clipped             = clip_r;
  assign cfg_ch.ready               = 1'b1;

  // An accepted sample always moves on to the memory read.
  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_READ)
    else $error("accepted sample did not start a memory read");

  // The tap sum completes only while the sequencer waits for it.
  a_mac_state: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> state_r == ST_MAC)
    else $error("tap sum completed outside its wait state");

  // The seed mixer completes only while the sequencer waits for it.
  a_seed_state: assert property (@(posedge clk) disable iff (!rst_n)
    seed_done |-> state_r == ST_SEED)
    else $error("seed mixer completed outside its wait state");

  // A register write marks every channel for reseeding.
  a_cfg_reseed: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_acc && (cfg_ch.index == CFG_BIT_DEPTH || cfg_ch.index == CFG_DITHER_MODE ||
                 cfg_ch.index == CFG_SEED)) |=> (&need_r))
    else $error("register write did not mark all channels for reseeding");

endmodule

@@ test/tb.sv @@
module tb;
  import pqd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Index outside the register map; a write to it must change nothing.
  localparam logic [1:0] CFG_UNMAPPED = 2'd3;
  localparam int NCH = 8;

  typedef struct packed {
    logic [2:0]         ch;
    logic signed [31:0] code;
    logic signed [31:0] code_lj;
    logic               clipped;
  } requant_result_t;

  logic clk;
  logic rst_n;

  pqd_in_if  in_if ();
  pqd_out_if out_if ();
  pqd_cfg_if cfg_if ();

  pcm_requantiser_noise_shaped_dither_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  // Shadow of the registers and the per-channel state.
  logic [5:0]  depth_reg;
  logic [1:0]  mode_reg;
  logic [31:0] seed_reg;
  logic [31:0] dither_gen [NCH];
  logic        reseed_due [NCH];
  longint      err_hist [NCH][TAPS];

  requant_result_t pending_results[$];
  int  error_count;
  int  samples_sent;
  int  results_checked;
  int  clips_seen;
  bit  idle_enable;
  int  hold_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // Seed mixer: 64-bit splitmix, low word kept, zero replaced by one.
  function automatic logic [31:0] mix_seed(logic [31:0] v);
    logic [63:0] w;
    w = {32'b0, v} + SM_GAMMA;
    w = (w ^ (w >> 30)) * SM_MUL1;
    w = (w ^ (w >> 27)) * SM_MUL2;
    w = w ^ (w >> 31);
    return (w[31:0] == 32'd0) ? 32'd1 : w[31:0];
  endfunction

  // One xorshift32 step; returns the draw in Q24 on [-1/2, 1/2).
  function automatic longint draw_dither(int c);
    logic [31:0] x;
    x = dither_gen[c];
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    dither_gen[c] = x;
    return longint'({40'b0, x[31:8]}) - longint'(64'd8388608);
  endfunction

  // Predicts one result and advances the channel state.
  function automatic requant_result_t requantise(logic [2:0] ch_in, logic signed [31:0] smp);
    requant_result_t r;
    int          c;
    int          bits;
    bit          shaped;
    longint      acc;
    longint      wanted;
    longint      cf;
    longint      flo;
    longint      rounded;
    longint      maxc;
    longint      code;
    logic [29:0] frac;
    logic [31:0] cw;
    c = ch_in % NCH;
    bits = (depth_reg < 2) ? 2 : ((depth_reg > 32) ? 32 : int'(depth_reg));
    shaped = (mode_reg == MODE_SHAPED);
    if (reseed_due[c]) begin
      dither_gen[c] = mix_seed(seed_reg + c);
      for (int k = 0; k < TAPS; k++) err_hist[c][k] = 0;
      reseed_due[c] = 1'b0;
    end
    acc = longint'(smp) <<< (bits - 2);
    // Error feedback: coefficients to Q20, products rounded to Q30.
    if (shaped) begin
      for (int k = 0; k < TAPS; k++) begin
        cf = (longint'(TAP_Q28[k]) + 128) >>> 8;
        acc += (cf * err_hist[c][k] + 8192) >>> 14;
      end
    end
    wanted = acc;
    if (mode_reg != MODE_PLAIN) begin
      cf = draw_dither(c);
      cf += draw_dither(c);
      acc += cf * 64;
    end
    // Round half to even.
    flo = acc >>> ACC_FRAC;
    frac = acc[29:0];
    rounded = flo;
    if (frac > 30'h2000_0000 || (frac == 30'h2000_0000 && flo[0])) rounded = flo + 1;
    if (shaped) begin
      for (int k = TAPS - 1; k > 0; k--) err_hist[c][k] = err_hist[c][k - 1];
      err_hist[c][0] = (wanted - (rounded <<< ACC_FRAC) + 32) >>> 6;
    end
    maxc = (longint'(1) <<< (bits - 1)) - 1;
    code = rounded;
    r.clipped = 1'b0;
    if (code > maxc) begin
      code = maxc;
      r.clipped = 1'b1;
    end else if (code < -maxc) begin
      code = -maxc;
      r.clipped = 1'b1;
    end
    cw = code[31:0];
    r.ch = ch_in;
    r.code = cw;
    r.code_lj = cw << (32 - bits);
    return r;
  endfunction

  // Sends one sample; valid stays high afterwards so the next one can follow.
  task automatic send_sample(logic [2:0] ch, logic signed [31:0] smp);
    int gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.channel <= ch;
    in_if.sample  <= smp;
    do @(posedge clk); while (!in_if.ready);
    pending_results.push_back(requantise(ch, smp));
    samples_sent++;
  endtask

  // Waits until the block has drained, then writes one register.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_BIT_DEPTH:   depth_reg = data[5:0];
      CFG_DITHER_MODE: mode_reg = data[1:0];
      CFG_SEED:        seed_reg = data;
      default:         return;
    endcase
    for (int c = 0; c < NCH; c++) reseed_due[c] = 1'b1;
  endtask

  function automatic logic signed [31:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $signed($urandom_range(0, 511)) - 256;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random stall bursts, plus a long hold on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 13);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    requant_result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("Result transaction with no sample outstanding");
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        results_checked++;
        if (out_if.clipped) clips_seen++;
        if (out_if.out_channel !== exp_r.ch) begin
          $error("out_channel: expected %0d, got %0d", exp_r.ch, out_if.out_channel);
          error_count++;
        end
        if (out_if.code !== exp_r.code) begin
          $error("code: expected %0d, got %0d", exp_r.code, out_if.code);
          error_count++;
        end
        if (out_if.code_left_justified !== exp_r.code_lj) begin
          $error("code_left_justified: expected %h, got %h",
                 exp_r.code_lj, out_if.code_left_justified);
          error_count++;
        end
        if (out_if.clipped !== exp_r.clipped) begin
          $error("clipped: expected %0d, got %0d", exp_r.clipped, out_if.clipped);
          error_count++;
        end
      end
    end
  end

  // Plain rounding at 24 bits: full scale, zero, ties to even.
  task automatic test_plain_rounding();
    write_reg(CFG_DITHER_MODE, MODE_PLAIN);
    send_sample(3'd0, 32'sh8000_0000);
    send_sample(3'd1, 32'sh7fff_ffff);
    send_sample(3'd2, 32'sd0);
    send_sample(3'd3, -32'sd1);
    send_sample(3'd4, 32'sd1);
    send_sample(3'd5, 32'sd128);
    send_sample(3'd6, 32'sd384);
    send_sample(3'd7, -32'sd128);
    send_sample(3'd7, -32'sd384);
  endtask

  // Register extremes: depths below 2 and above 32, mode three, bad index, seeds all ones and zero.
  task automatic test_register_extremes();
    logic [5:0] depths [6] = '{6'd0, 6'd1, 6'd2, 6'd32, 6'd33, 6'd63};
    write_reg(CFG_SEED, 32'hffff_ffff);
    write_reg(CFG_DITHER_MODE, MODE_SHAPED);
    foreach (depths[i]) begin
      write_reg(CFG_BIT_DEPTH, depths[i]);
      send_sample(3'd0, 32'sh7fff_ffff);
      send_sample(3'd7, 32'sh8000_0000);
    end
    write_reg(CFG_DITHER_MODE, 32'd3);
    send_sample(3'd2, 32'sd1000);
    write_reg(CFG_UNMAPPED, 32'h1234_5678);
    send_sample(3'd2, 32'sd1000);
    write_reg(CFG_SEED, 32'd0);
    send_sample(3'd5, 32'sd0);
  endtask

  // Random settings and samples; one phase stalls the receiver at length.
  task automatic test_random_phases();
    logic [5:0] d;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 5))
        0:       d = $urandom_range(0, 63);
        1:       d = 6'd32;
        2:       d = 6'd2;
        default: d = $urandom_range(8, 24);
      endcase
      write_reg(CFG_BIT_DEPTH, d);
      write_reg(CFG_DITHER_MODE, $urandom_range(0, 3));
      if ($urandom_range(0, 1)) write_reg(CFG_SEED, $urandom);
      if (ph == 4) hold_cycles = 400;
      repeat (140) send_sample($urandom_range(0, 7), pick_sample());
    end
  endtask

  // Last stretch at full throughput in shaped mode.
  task automatic test_no_idle();
    write_reg(CFG_BIT_DEPTH, 6'd16);
    write_reg(CFG_DITHER_MODE, MODE_SHAPED);
    idle_enable = 1'b0;
    repeat (300) send_sample($urandom_range(0, 7), pick_sample());
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.channel = '0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_BIT_DEPTH;
    cfg_if.data = '0;
    depth_reg = RST_BIT_DEPTH;
    mode_reg = MODE_SHAPED;
    seed_reg = '0;
    for (int c = 0; c < NCH; c++) begin
      dither_gen[c] = '0;
      reseed_due[c] = 1'b1;
      for (int k = 0; k < TAPS; k++) err_hist[c][k] = 0;
    end
    error_count = 0;
    samples_sent = 0;
    results_checked = 0;
    clips_seen = 0;
    idle_enable = 1'b1;
    hold_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default registers first, then the named tests.
    send_sample(3'd1, 32'sd12345);
    send_sample(3'd1, -32'sd12345);
    test_plain_rounding();
    test_register_extremes();
    test_random_phases();
    test_no_idle();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Requantised %0d samples over all modes and depths, %0d results checked,",
             samples_sent, results_checked);
    $display("%0d of them clipped; a long receiver stall filled the block once.", clips_seen);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
